>>> sv/bki_pkg.sv
`default_nettype none
package bki_pkg;

  // Field widths
  localparam int unsigned ANGLE_W = 18;
  localparam int unsigned SPEED_W = 24;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned HEAD_W  = 16;
  localparam int unsigned STEP_W  = 16;
  localparam int unsigned INVWB_W = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // Parameter defaults
  localparam int unsigned CORDIC_ITERATIONS_DEF = 16;
  localparam int unsigned PHASE_BITS_DEF        = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_WHEELBASE = 2'd1;

  localparam logic [STEP_W-1:0]  STEP_TIME_RST = 16'd6554;
  localparam logic [INVWB_W-1:0] INV_WB_RST    = 24'd65536;

  // Iteration counter covers the divider (56 quotient bits) and the CORDIC
  localparam int unsigned DIV_STEPS = 56;
  localparam int unsigned CNT_W     = 6;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] steer_angle;
    logic signed [SPEED_W-1:0] speed_in;
  } in_word_t;

  typedef struct packed {
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic        [HEAD_W-1:0]  heading_out;
    logic signed [SPEED_W-1:0] speed_out;
    logic                      pos_saturated;
  } out_word_t;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_MUL_DS,
    OP_RND_DS,
    OP_CRD_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL_K,
    OP_RND_K,
    OP_MUL_DR,
    OP_RND_DR,
    OP_MUL_PLO,
    OP_MUL_PHI,
    OP_PHASE,
    OP_MUL_Z,
    OP_RND_Z,
    OP_MUL_DX,
    OP_RND_DX,
    OP_MUL_DY,
    OP_RND_DY,
    OP_OUT
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DS_MUL,
    S_DS_RND,
    S_CS_RUN,
    S_DIV_INIT,
    S_DIV_RUN,
    S_K_MUL,
    S_K_RND,
    S_DR_MUL,
    S_DR_RND,
    S_PLO,
    S_PHI,
    S_PHASE,
    S_Z_MUL,
    S_Z_RND,
    S_CH_RUN,
    S_DX_MUL,
    S_DX_RND,
    S_DY_MUL,
    S_DY_RND,
    S_OUT
  } state_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic crd_last;
    logic div_last;
  } sts_t;

  // Arithmetic constants
  localparam logic signed [ANGLE_W-1:0] STEER_LIMIT = 18'sd98304;
  localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032874;
  localparam logic [31:0] HALF_PI_Q30   = 32'd1686629713;
  localparam logic [31:0] INV_2PI_Q32   = 32'd683565276;
  localparam logic [31:0] COS_FLOOR     = 32'd1048576;
  localparam logic [55:0] TAN_LIMIT     = 56'd268435456;

  localparam logic [30:0] ATAN_Q30 [32] = '{
    31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
    31'd33543515, 31'd16775850, 31'd8388437, 31'd4194282, 31'd2097149,
    31'd1048575, 31'd524287, 31'd262143, 31'd131071, 31'd65535, 31'd32767,
    31'd16383, 31'd8191, 31'd4095, 31'd2047, 31'd1023, 31'd511, 31'd255,
    31'd127, 31'd63, 31'd31, 31'd15, 31'd8, 31'd4, 31'd2, 31'd1, 31'd0
  };

endpackage
`default_nettype wire

>>> sv/bicycle_kinematics_integrator.sv
// Channel  Direction  Handshake                 Word
// in       input      in_valid_i / in_stall_o   in_word_i   (steer_angle, speed_in)
// out      output     out_valid_o / out_stall_i out_word_o  (x, y, heading, speed, sat)
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A result lands in the output register when the sequencer reaches its output state
// for the accepted word; a new word is taken once the sequencer is back in idle.
// The step runs two serial CORDIC passes, a 56-step restoring divider for the
// tangent and a chain of rounded products through one 32x32 multiplier.
// Reset (rst_ni low, asynchronous) clears pose, heading and speed and loads
// the register defaults. A stalled result waits in the output register while
// the next word is accepted and processed; it is only overwritten once taken.
`default_nettype none
module bicycle_kinematics_integrator import bki_pkg::*; #(
  parameter int unsigned CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF,
  parameter int unsigned PHASE_BITS        = PHASE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_word_t              in_word_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_word_t                  out_word_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // Registers are always writable; writes must only come while idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  // Sequencer: one state per datapath operation, loops on the iterative units
  bki_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Pose state, CORDIC, divider, shared multiplier and output register
  bki_dpath #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
    .PHASE_BITS        (PHASE_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_word_o  (out_word_o)
  );

endmodule
`default_nettype wire

>>> sv/bki_ctrl.sv
`default_nettype none
module bki_ctrl import bki_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = OP_IDLE;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DS_MUL;
        end
      end
      S_DS_MUL: begin cmd_o.op = OP_MUL_DS; state_d = S_DS_RND; end
      S_DS_RND: begin cmd_o.op = OP_RND_DS; state_d = S_CS_RUN; end
      S_CS_RUN: begin
        cmd_o.op = OP_CRD_STEP;
        if (sts_i.crd_last) state_d = S_DIV_INIT;
      end
      S_DIV_INIT: begin cmd_o.op = OP_DIV_INIT; state_d = S_DIV_RUN; end
      S_DIV_RUN: begin
        cmd_o.op = OP_DIV_STEP;
        if (sts_i.div_last) state_d = S_K_MUL;
      end
      S_K_MUL:  begin cmd_o.op = OP_MUL_K;   state_d = S_K_RND;  end
      S_K_RND:  begin cmd_o.op = OP_RND_K;   state_d = S_DR_MUL; end
      S_DR_MUL: begin cmd_o.op = OP_MUL_DR;  state_d = S_DR_RND; end
      S_DR_RND: begin cmd_o.op = OP_RND_DR;  state_d = S_PLO;    end
      S_PLO:    begin cmd_o.op = OP_MUL_PLO; state_d = S_PHI;    end
      S_PHI:    begin cmd_o.op = OP_MUL_PHI; state_d = S_PHASE;  end
      S_PHASE:  begin cmd_o.op = OP_PHASE;   state_d = S_Z_MUL;  end
      S_Z_MUL:  begin cmd_o.op = OP_MUL_Z;   state_d = S_Z_RND;  end
      S_Z_RND:  begin cmd_o.op = OP_RND_Z;   state_d = S_CH_RUN; end
      S_CH_RUN: begin
        cmd_o.op = OP_CRD_STEP;
        if (sts_i.crd_last) state_d = S_DX_MUL;
      end
      S_DX_MUL: begin cmd_o.op = OP_MUL_DX; state_d = S_DX_RND; end
      S_DX_RND: begin cmd_o.op = OP_RND_DX; state_d = S_DY_MUL; end
      S_DY_MUL: begin cmd_o.op = OP_MUL_DY; state_d = S_DY_RND; end
      S_DY_RND: begin cmd_o.op = OP_RND_DY; state_d = S_OUT;    end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> state_q == S_DS_MUL)
    else $error("accepted word did not start the step");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("result raised outside the output state");

  a_cordic_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CS_RUN && !sts_i.crd_last) |=> state_q == S_CS_RUN)
    else $error("steering CORDIC left early");

  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV_RUN && sts_i.div_last) |=> state_q == S_K_MUL)
    else $error("divider did not hand over to curvature multiply");

endmodule
`default_nettype wire

>>> sv/bki_dpath.sv
`default_nettype none
module bki_dpath import bki_pkg::*; #(
  parameter int unsigned CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF,
  parameter int unsigned PHASE_BITS        = PHASE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire in_word_t              in_word_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire cmd_t                  cmd_i,
  output sts_t                       sts_o,
  output out_word_t                  out_word_o
);

  function automatic logic [33:0] abs34(input logic signed [33:0] v);
    abs34 = v[33] ? 34'(-v) : 34'(v);
  endfunction

  // (p + 2^(s-1)) >> s on the magnitude
  function automatic logic [63:0] rnd_shr(input logic [63:0] p, input int unsigned s);
    rnd_shr = (p + (64'd1 << (s - 1))) >> s;
  endfunction

  logic [STEP_W-1:0]  step_time_q;
  logic [INVWB_W-1:0] inv_wb_q;

  logic signed [POS_W-1:0]   x_acc_q, y_acc_q;
  logic [PHASE_BITS-1:0]     phase_q;
  logic signed [SPEED_W-1:0] last_speed_q;

  logic signed [28:0] ds_q;
  logic signed [32:0] k_q;
  logic signed [52:0] dr_q;
  logic signed [33:0] crd_x_q, crd_y_q, crd_z_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [31:0]        rem_q, c_q;
  logic [55:0]        div_n_q;
  logic               s_neg_q;
  logic [63:0]        p_q, plo_q;
  logic               neg_q;
  logic               sat_q;
  out_word_t          out_q;

  // Operand selection for the shared multiplier
  logic [31:0] a_mag, b_mag;
  logic        m_neg, mul_en;
  logic [63:0] prod;

  logic signed [ANGLE_W-1:0] ang_c;
  logic signed [33:0] cx, sy;
  logic [1:0]  quad;
  logic [29:0] r30;
  logic [63:0] dr64;
  logic [55:0] t_full;
  logic [28:0] t_mag;

  assign ang_c = (in_word_i.steer_angle > STEER_LIMIT)  ? STEER_LIMIT :
                 (in_word_i.steer_angle < -STEER_LIMIT) ? -STEER_LIMIT :
                 in_word_i.steer_angle;

  assign quad = phase_q[PHASE_BITS-1 -: 2];
  generate
    if (PHASE_BITS >= 32) begin : g_r30_wide
      assign r30 = phase_q[PHASE_BITS-3 -: 30];
    end else begin : g_r30_narrow
      assign r30 = {phase_q[PHASE_BITS-3:0], {(32-PHASE_BITS){1'b0}}};
    end
  endgenerate

  always_comb begin
    unique case (quad)
      2'd0: begin cx = crd_x_q;  sy = crd_y_q;  end
      2'd1: begin cx = -crd_y_q; sy = crd_x_q;  end
      2'd2: begin cx = -crd_x_q; sy = -crd_y_q; end
      default: begin cx = crd_y_q; sy = -crd_x_q; end
    endcase
  end

  assign dr64   = 64'(dr_q);
  assign t_full = (div_n_q > TAN_LIMIT) ? TAN_LIMIT : div_n_q;
  assign t_mag  = t_full[28:0];

  always_comb begin
    a_mag  = '0;
    b_mag  = '0;
    m_neg  = 1'b0;
    mul_en = 1'b1;
    unique case (cmd_i.op)
      OP_MUL_DS: begin
        a_mag = 32'(step_time_q);
        b_mag = 32'(abs34(34'(last_speed_q)));
        m_neg = last_speed_q[SPEED_W-1];
      end
      OP_MUL_K: begin
        a_mag = 32'(inv_wb_q);
        b_mag = 32'(t_mag);
        m_neg = s_neg_q;
      end
      OP_MUL_DR: begin
        a_mag = 32'(abs34(34'(ds_q)));
        b_mag = 32'(abs34(34'(k_q)));
        m_neg = ds_q[28] ^ k_q[32];
      end
      OP_MUL_PLO: begin a_mag = dr64[31:0];  b_mag = INV_2PI_Q32; end
      OP_MUL_PHI: begin a_mag = dr64[63:32]; b_mag = INV_2PI_Q32; end
      OP_MUL_Z:   begin a_mag = 32'(r30);    b_mag = HALF_PI_Q30; end
      OP_MUL_DX: begin
        a_mag = 32'(abs34(34'(ds_q)));
        b_mag = 32'(abs34(cx));
        m_neg = ds_q[28] ^ cx[33];
      end
      OP_MUL_DY: begin
        a_mag = 32'(abs34(34'(ds_q)));
        b_mag = 32'(abs34(sy));
        m_neg = ds_q[28] ^ sy[33];
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign prod = 64'(a_mag) * 64'(b_mag);

  // Rounded, signed result of the registered product
  logic [63:0] r_ds, r_k, r_dr, r_z, r_d34;
  logic signed [63:0] s_d34;
  assign r_ds  = rnd_shr(p_q, 12);
  assign r_k   = rnd_shr(p_q, 20);
  assign r_dr  = rnd_shr(p_q, 8);
  assign r_z   = rnd_shr(p_q, 30);
  assign r_d34 = rnd_shr(p_q, 34);
  assign s_d34 = neg_q ? -$signed(r_d34) : $signed(r_d34);

  // Saturating position update, shared by x and y
  logic signed [POS_W-1:0] acc_sel;
  logic signed [POS_W:0]   acc_sum;
  logic signed [POS_W-1:0] acc_new;
  logic                    acc_ovf;
  assign acc_sel = (cmd_i.op == OP_RND_DX) ? x_acc_q : y_acc_q;
  assign acc_sum = 33'(acc_sel) + 33'(s_d34[32:0]);
  assign acc_ovf = acc_sum[POS_W] ^ acc_sum[POS_W-1];
  assign acc_new = !acc_ovf ? acc_sum[POS_W-1:0] :
                   acc_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};

  // Heading increment
  logic [63:0] dp64;
  assign dp64 = plo_q + {p_q[31:0], 32'd0} + (64'd1 << (63 - PHASE_BITS));

  // CORDIC micro-rotation
  logic [4:0]         idx;
  logic signed [33:0] xs, ys, at;
  assign idx = cnt_q[4:0];
  assign xs  = crd_x_q >>> idx;
  assign ys  = crd_y_q >>> idx;
  assign at  = $signed({3'b000, ATAN_Q30[idx]});

  // Restoring divider step
  logic [32:0] trial;
  logic        ge;
  assign trial = {rem_q, div_n_q[55]};
  assign ge    = trial >= {1'b0, c_q};

  logic [33:0] sm;
  assign sm = abs34(crd_y_q);

  assign sts_o.crd_last = (cnt_q == CNT_W'(CORDIC_ITERATIONS - 1));
  assign sts_o.div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));

  // Configuration, model state, counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_time_q  <= STEP_TIME_RST;
      inv_wb_q     <= INV_WB_RST;
      x_acc_q      <= '0;
      y_acc_q      <= '0;
      phase_q      <= '0;
      last_speed_q <= '0;
      cnt_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_STEP_TIME) step_time_q <= cfg_data_i[STEP_W-1:0];
        else if (cfg_index_i == REG_INV_WHEELBASE) inv_wb_q <= cfg_data_i[INVWB_W-1:0];
      end
      unique case (cmd_i.op)
        OP_LOAD: begin
          last_speed_q <= in_word_i.speed_in;
          cnt_q        <= '0;
        end
        OP_RND_Z, OP_DIV_INIT: cnt_q <= '0;
        OP_CRD_STEP, OP_DIV_STEP: cnt_q <= cnt_q + 1'b1;
        OP_PHASE: phase_q <= phase_q + dp64[63 -: PHASE_BITS];
        OP_RND_DX: x_acc_q <= acc_new;
        OP_RND_DY: y_acc_q <= acc_new;
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      p_q   <= prod;
      neg_q <= m_neg;
    end
    unique case (cmd_i.op)
      OP_LOAD: begin
        crd_x_q <= INV_GAIN_Q30;
        crd_y_q <= '0;
        crd_z_q <= {{2{ang_c[ANGLE_W-1]}}, ang_c, 14'd0};
      end
      OP_RND_DS: ds_q <= neg_q ? -$signed(r_ds[28:0]) : $signed(r_ds[28:0]);
      OP_CRD_STEP: begin
        if (!crd_z_q[33]) begin
          crd_x_q <= crd_x_q - ys;
          crd_y_q <= crd_y_q + xs;
          crd_z_q <= crd_z_q - at;
        end else begin
          crd_x_q <= crd_x_q + ys;
          crd_y_q <= crd_y_q - xs;
          crd_z_q <= crd_z_q + at;
        end
      end
      OP_DIV_INIT: begin
        c_q     <= (crd_x_q < $signed({2'b00, COS_FLOOR})) ? COS_FLOOR : crd_x_q[31:0];
        s_neg_q <= crd_y_q[33];
        div_n_q <= {sm[31:0], 24'd0};
        rem_q   <= '0;
      end
      OP_DIV_STEP: begin
        rem_q   <= ge ? 32'(trial - {1'b0, c_q}) : trial[31:0];
        div_n_q <= {div_n_q[54:0], ge};
      end
      OP_RND_K:   k_q  <= neg_q ? -$signed(r_k[32:0]) : $signed(r_k[32:0]);
      OP_RND_DR:  dr_q <= neg_q ? -$signed(r_dr[52:0]) : $signed(r_dr[52:0]);
      OP_MUL_PHI: plo_q <= p_q;
      OP_RND_Z: begin
        crd_x_q <= INV_GAIN_Q30;
        crd_y_q <= '0;
        crd_z_q <= $signed(r_z[33:0]);
      end
      OP_RND_DX: sat_q <= acc_ovf;
      OP_RND_DY: sat_q <= sat_q | acc_ovf;
      OP_OUT: begin
        out_q.pos_x         <= x_acc_q;
        out_q.pos_y         <= y_acc_q;
        out_q.heading_out   <= phase_q[PHASE_BITS-1 -: HEAD_W];
        out_q.speed_out     <= last_speed_q;
        out_q.pos_saturated <= sat_q;
      end
      default: ;
    endcase
  end

  assign out_word_o = out_q;

endmodule
`default_nettype wire

>>> tb/bicycle_kinematics_integrator_test.sv
`timescale 1ns / 1ps
module bicycle_kinematics_integrator_test;
  import bki_pkg::*;

  localparam int unsigned IDLE_LIMIT = 20000;  // cycles with no word moving
  localparam int unsigned DRAIN_WAIT = 150;    // longer than one step's latency
  localparam int unsigned RAND_ITEMS = 1080;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_word_t in_word;
  logic out_valid;
  logic out_stall;
  out_word_t out_word;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // copies of the block's outputs taken mid-cycle, stable across the edge
  logic in_stall_s;
  logic out_valid_s;
  logic cfg_ready_s;
  out_word_t out_word_s;

  bicycle_kinematics_integrator dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_word_i(in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o(out_word),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    in_stall_s  = in_stall;
    out_valid_s = out_valid;
    cfg_ready_s = cfg_ready;
    out_word_s  = out_word;
  end

  // ---------------------------------------------------------------------
  // Pose predictor: own copy of pose, heading phase and registers
  // ---------------------------------------------------------------------
  longint    pose_x;
  longint    pose_y;
  bit [31:0] head_phase;
  bit [15:0] dt_reg;
  bit [23:0] inv_wb_reg;

  out_word_t pose_q[$];   // expected result words, oldest first
  int errors;
  int words_sent;
  int words_seen;
  int sat_seen;
  int cfg_writes;

  // product shifted right, rounded half away from zero on the magnitude
  function automatic longint round_mul(longint a, longint b, int sh);
    bit neg;
    bit [63:0] ua, ub, r;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    r = (ua * ub + (64'd1 << (sh - 1))) >> sh;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // rotation-mode CORDIC, angle in Q2.30, starts at 1/K so no gain to undo
  task automatic rotate(input longint z, output longint c, output longint s);
    longint xv, yv, xs, ys;
    xv = 652032874;
    yv = 0;
    for (int i = 0; i < CORDIC_ITERATIONS_DEF; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (z >= 0) begin
        xv = xv - ys; yv = yv + xs; z = z - longint'(ATAN_Q30[i]);
      end else begin
        xv = xv + ys; yv = yv - xs; z = z + longint'(ATAN_Q30[i]);
      end
    end
    c = xv;
    s = yv;
  endtask

  task automatic advance_pose(input in_word_t w, output out_word_t r);
    longint ang, spd, ds, c, s, t, k, dr, hc, hs, cx, sy, nx, ny;
    bit [63:0] mag, dp, zq;
    bit sat;
    ang = longint'($signed(w.steer_angle));
    spd = longint'($signed(w.speed_in));
    sat = 1'b0;
    if (ang > 98304) ang = 98304;
    if (ang < -98304) ang = -98304;
    ds = round_mul(longint'(dt_reg), spd, 12);
    rotate(ang * 16384, c, s);
    if (c < (64'sd1 <<< 20)) c = 64'sd1 <<< 20;   // cosine floor near +-pi/2
    mag = (s < 0) ? -s : s;
    t = longint'((mag << 24) / c);
    if (t > (64'sd16 <<< 24)) t = 64'sd16 <<< 24; // tangent limit
    if (s < 0) t = -t;
    k  = round_mul(longint'(inv_wb_reg), t, 20);
    dr = round_mul(ds, k, 8);
    dp = (64'(dr) * 64'd683565276 + (64'd1 << 31)) >> 32;
    head_phase = head_phase + dp[31:0];
    zq = (64'(head_phase[29:0]) * 64'd1686629713 + (64'd1 << 29)) >> 30;
    rotate(longint'(zq), hc, hs);
    case (head_phase[31:30])
      2'd0: begin cx = hc;  sy = hs;  end
      2'd1: begin cx = -hs; sy = hc;  end
      2'd2: begin cx = -hc; sy = -hs; end
      default: begin cx = hs; sy = -hc; end
    endcase
    nx = pose_x + round_mul(ds, cx, 34);
    ny = pose_y + round_mul(ds, sy, 34);
    if (nx > 64'sd2147483647)  begin nx = 64'sd2147483647;  sat = 1'b1; end
    if (nx < -64'sd2147483648) begin nx = -64'sd2147483648; sat = 1'b1; end
    if (ny > 64'sd2147483647)  begin ny = 64'sd2147483647;  sat = 1'b1; end
    if (ny < -64'sd2147483648) begin ny = -64'sd2147483648; sat = 1'b1; end
    pose_x = nx;
    pose_y = ny;
    r.pos_x = nx[31:0];
    r.pos_y = ny[31:0];
    r.heading_out = head_phase[31:16];
    r.speed_out = w.speed_in;
    r.pos_saturated = sat;
  endtask

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch at word %0d: %s got %0d want %0d", words_seen, what, got, want);
  endtask

  // ---------------------------------------------------------------------
  // Output side: stall pattern, checking, watchdog
  // ---------------------------------------------------------------------
  int stall_pct;
  int stall_left;
  int idle_cycles;

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_pct = 0;
      stall_left = 0;
    end else begin
      if (out_valid_s && !out_stall) begin
        words_seen++;
        if (pose_q.size() == 0) begin
          report("unexpected result", 64'sd1, 64'sd0);
        end else begin
          want = pose_q.pop_front();
          if (out_word_s.pos_x !== want.pos_x)
            report("pos_x", longint'($signed(out_word_s.pos_x)),
                   longint'($signed(want.pos_x)));
          if (out_word_s.pos_y !== want.pos_y)
            report("pos_y", longint'($signed(out_word_s.pos_y)),
                   longint'($signed(want.pos_y)));
          if (out_word_s.heading_out !== want.heading_out)
            report("heading_out", longint'(out_word_s.heading_out),
                   longint'(want.heading_out));
          if (out_word_s.speed_out !== want.speed_out)
            report("speed_out", longint'($signed(out_word_s.speed_out)),
                   longint'($signed(want.speed_out)));
          if (out_word_s.pos_saturated !== want.pos_saturated)
            report("pos_saturated", longint'(out_word_s.pos_saturated),
                   longint'(want.pos_saturated));
          if (want.pos_saturated) sat_seen++;
        end
      end
      // stall duty is redrawn whenever its random run length ends: none, light, heavy, near-solid
      if (stall_left == 0) begin
        stall_left = $urandom_range(50, 400);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 95;
        endcase
      end
      stall_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall_s) || (out_valid_s && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles", idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------
  int burst_left;

  // one word, in bursts with random gaps; typed expectations replace the
  // predicted one but the predictor still advances its state
  task automatic send(input in_word_t w, input bit typed, input out_word_t want);
    out_word_t r;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall_s);
    advance_pose(w, r);
    pose_q.push_back(typed ? want : r);
    words_sent++;
    burst_left--;
  endtask

  // sender pauses until every word is back, then lets the pipeline empty
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready_s);
    cfg_valid <= 1'b0;
    if (idx == REG_STEP_TIME) dt_reg = val[15:0];
    else if (idx == REG_INV_WHEELBASE) inv_wb_reg = val;
    cfg_writes++;
  endtask

  function automatic in_word_t rand_word();
    in_word_t w;
    case ($urandom_range(0, 9))
      0: w.steer_angle = ANGLE_W'($urandom());   // full field, clamp path
      1: w.steer_angle = ($urandom_range(0, 1) != 0) ? 18'sd98304 : -18'sd98304;
      default: w.steer_angle = ANGLE_W'($signed($urandom_range(0, 196608)) - 98304);
    endcase
    case ($urandom_range(0, 3))
      0: w.speed_in = SPEED_W'($urandom());
      1: w.speed_in = SPEED_W'($signed($urandom_range(0, 4194304)) - 2097152);
      default: w.speed_in = SPEED_W'($signed($urandom_range(0, 3000000)) - 1000000);
    endcase
    return w;
  endfunction

  typedef struct {
    logic signed [ANGLE_W-1:0] ang;
    logic signed [SPEED_W-1:0] spd;
    bit typed;
  } steer_row_t;

  steer_row_t steer_rows [14];
  out_word_t zero_word;
  out_word_t none_word;

  initial begin
    in_word_t w;
    int n;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst_n = 1'b0;
    errors = 0;
    words_sent = 0;
    words_seen = 0;
    sat_seen = 0;
    cfg_writes = 0;
    burst_left = 0;
    idle_cycles = 0;
    pose_x = 0;
    pose_y = 0;
    head_phase = '0;
    dt_reg = STEP_TIME_RST;
    inv_wb_reg = INV_WB_RST;
    zero_word = '0;
    none_word = '0;

    // typed rows: zero speed from reset, nothing moves, so the word is all zero
    steer_rows = '{
      '{18'sd0,       24'sd0,        1'b1},
      '{18'sd98304,   24'sd0,        1'b1},
      '{-18'sd98304,  24'sd0,        1'b1},
      '{18'sd131071,  24'sd0,        1'b1},  // out of range, clamped
      '{-18'sd131072, 24'sd0,        1'b1},
      '{18'sd0,       24'sd65536,    1'b0},
      '{18'sd131071,  24'sd65536,    1'b0},
      '{-18'sd131072, -24'sd65536,   1'b0},
      '{18'sd98304,   24'sd8388607,  1'b0},
      '{-18'sd98304,  -24'sd8388608, 1'b0},
      '{18'sd1,       24'sd1,        1'b0},
      '{-18'sd1,      -24'sd1,       1'b0},
      '{18'sd65536,   24'sd327680,   1'b0},
      '{-18'sd65536,  24'sd327680,   1'b0}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steer_rows[i]) begin
      w.steer_angle = steer_rows[i].ang;
      w.speed_in = steer_rows[i].spd;
      send(w, steer_rows[i].typed, zero_word);
    end
    drain();

    // longest step, no turning: drive straight until the position clamps
    write_reg(REG_STEP_TIME, 24'd65535);
    write_reg(REG_INV_WHEELBASE, 24'd0);
    for (int i = 0; i < 400; i++) begin
      w = rand_word();
      w.speed_in = 24'sd8388607;
      send(w, 1'b0, none_word);
    end
    drain();

    // widest turning, shortest step
    write_reg(REG_STEP_TIME, 24'd1);
    write_reg(REG_INV_WHEELBASE, 24'd16777215);
    for (int i = 0; i < 120; i++) send(rand_word(), 1'b0, none_word);
    drain();

    // zero step time; unknown indexes must leave the registers alone
    write_reg(REG_STEP_TIME, 24'd0);
    write_reg(REG_INV_WHEELBASE, 24'd1);
    write_reg(2'd2, 24'hFFFFFF);
    write_reg(2'd3, CFG_DATA_W'($urandom()));
    for (int i = 0; i < 60; i++) send(rand_word(), 1'b0, none_word);
    drain();

    // strong turning with real motion: heading wraps many times
    write_reg(REG_STEP_TIME, 24'd65535);
    write_reg(REG_INV_WHEELBASE, 24'd2000000);
    for (int i = 0; i < 150; i++) send(rand_word(), 1'b0, none_word);
    drain();

    // the rest under random register settings, upper data bits random too
    n = words_sent;
    while (words_sent < n + (RAND_ITEMS - 730)) begin
      write_reg(REG_STEP_TIME, CFG_DATA_W'($urandom()));
      write_reg(REG_INV_WHEELBASE, CFG_DATA_W'($urandom_range(1, 16777215)));
      for (int i = 0; i < 70; i++) send(rand_word(), 1'b0, none_word);
      drain();
    end

    drain();
    $display("covered %0d words, %0d results, %0d clamped positions, %0d register writes",
             words_sent, words_seen, sat_seen, cfg_writes);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
